[hw/rtl/kwsc_pkg.sv]
// kwsc_pkg: shared types and constants for the keyword substitution cipher
// used by kwsc_table and keyword_substitution_cipher; no dependencies

package kwsc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int IDX_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CNT_W         = $clog2(ALPHABET_SIZE + 1);

    localparam logic [7:0] FIRST_LETTER = 8'h41;

    // opcodes
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_KEY     = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;
    localparam logic [1:0] OP_ENCRYPT = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_in;
    } kwsc_in_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic [1:0] status;
    } kwsc_out_t;

    // table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } kwsc_wr_t;

    // table read port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } kwsc_rd_t;

endpackage

[hw/rtl/keyword_substitution_cipher.sv]
// keyword_substitution_cipher: top level, sequencer around the table write path
// depends on kwsc_pkg and kwsc_table
//
//   channel  | signals                         | direction | carries
//   ---------+---------------------------------+-----------+---------------------
//   request  | req_valid, req_ready, req       | in        | opcode, data_in
//   response | rsp_valid, rsp_ready, rsp       | out       | data_out, status
//
// one request transaction at a time, exactly one response transaction each
// clear, key letter, refused items and non-letter encrypts: response valid the next cycle
// encrypt of a letter on a sealed table: goes through S_READ, for the registered read port of the table memory
// finish: after the accept, S_FILL steps through all 26 alphabet letters on the append path
// rst_n clears control state and the used-letter bits; table contents stay undefined
// a stalled response holds in its register; no request is taken until it leaves

module keyword_substitution_cipher
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  kwsc_pkg::kwsc_in_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output kwsc_pkg::kwsc_out_t rsp
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILL = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]                           state_reg, state_next;
    logic [kwsc_pkg::ALPHABET_SIZE-1:0]   used_reg, used_next;
    logic [kwsc_pkg::CNT_W-1:0]           fill_reg, fill_next;
    logic [kwsc_pkg::IDX_W-1:0]           scan_reg, scan_next;
    logic                                 sealed_reg, sealed_next;
    logic [7:0]                           byte_reg, byte_next;
    kwsc_pkg::kwsc_out_t                  rsp_reg, rsp_next;

    kwsc_pkg::kwsc_wr_t                   wr;
    kwsc_pkg::kwsc_rd_t                   rd;
    logic [kwsc_pkg::IDX_W-1:0]           rd_data;

    // letter decode of the incoming byte
    logic [7:0]                           diff;
    logic                                 is_letter;
    logic [kwsc_pkg::IDX_W-1:0]           in_idx;
    logic                                 room;

    assign diff      = req.data_in - kwsc_pkg::FIRST_LETTER;
    assign is_letter = (req.data_in >= kwsc_pkg::FIRST_LETTER)
                       && (diff < 8'(kwsc_pkg::ALPHABET_SIZE));
    assign in_idx    = diff[kwsc_pkg::IDX_W-1:0];
    assign room      = fill_reg < kwsc_pkg::CNT_W'(kwsc_pkg::ALPHABET_SIZE);

    kwsc_table u_table
    (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        fill_next   = fill_reg;
        scan_next   = scan_reg;
        sealed_next = sealed_reg;
        byte_next   = byte_reg;
        rsp_next    = rsp_reg;
        wr.en       = 1'b0;
        wr.addr     = fill_reg[kwsc_pkg::IDX_W-1:0];
        wr.data     = in_idx;
        rd.en       = 1'b0;
        rd.addr     = in_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    byte_next         = req.data_in;
                    rsp_next.data_out = req.data_in;
                    rsp_next.status   = kwsc_pkg::ST_OK;
                    state_next        = S_RESP;
                    case (req.opcode)
                        kwsc_pkg::OP_CLEAR:
                        begin
                            used_next   = '0;
                            fill_next   = '0;
                            sealed_next = 1'b0;
                        end
                        kwsc_pkg::OP_KEY:
                        begin
                            if (sealed_reg || !is_letter || used_reg[in_idx])
                            begin
                                rsp_next.status = kwsc_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                // append the new key letter
                                used_next[in_idx] = 1'b1;
                                if (room)
                                begin
                                    wr.en     = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                        kwsc_pkg::OP_FINISH:
                        begin
                            if (sealed_reg)
                            begin
                                rsp_next.status = kwsc_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_FILL;
                            end
                        end
                        default:
                        begin
                            if (!sealed_reg)
                            begin
                                rsp_next.status = kwsc_pkg::ST_NOT_READY;
                            end
                            else if (is_letter)
                            begin
                                // look up the table, mapped byte comes next cycle
                                rd.en      = 1'b1;
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                // one letter per cycle: append it when the keyword did not use it
                wr.data = scan_reg;
                if (!used_reg[scan_reg])
                begin
                    used_next[scan_reg] = 1'b1;
                    if (room)
                    begin
                        wr.en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                if (scan_reg == kwsc_pkg::IDX_W'(kwsc_pkg::ALPHABET_SIZE - 1))
                begin
                    sealed_next       = 1'b1;
                    rsp_next.data_out = byte_reg;
                    rsp_next.status   = kwsc_pkg::ST_OK;
                    state_next        = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_READ:
            begin
                rsp_next.data_out = kwsc_pkg::FIRST_LETTER + 8'(rd_data);
                rsp_next.status   = kwsc_pkg::ST_OK;
                state_next        = S_RESP;
            end
            default:
            begin
                // response waits here until the transaction completes
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            fill_reg   <= '0;
            sealed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            fill_reg   <= fill_next;
            sealed_reg <= sealed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        byte_reg <= byte_next;
        rsp_reg  <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/kwsc_table.sv]
// kwsc_table: substitution table memory, one write and one registered read port
// depends on kwsc_pkg

module kwsc_table
(
    input  logic                      clk,
    input  kwsc_pkg::kwsc_wr_t        wr,
    input  kwsc_pkg::kwsc_rd_t        rd,
    output logic [kwsc_pkg::IDX_W-1:0] rd_data
);

    logic [kwsc_pkg::IDX_W-1:0] mem [kwsc_pkg::ALPHABET_SIZE];
    logic [kwsc_pkg::IDX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sim/kwsc_cipher_checker.sv]
// kwsc_cipher_checker: watches both channels of the keyword substitution cipher,
// predicts each response from the request stream and compares it field by field
// depends on kwsc_pkg

module kwsc_cipher_checker
    import kwsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  kwsc_in_t  req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  kwsc_out_t rsp,
    output int        fail_count,
    output int        outstanding
);

    // predicted cipher state
    logic [IDX_W-1:0]         key_table [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] taken;
    int                       fill;
    logic                     sealed;

    kwsc_out_t cipher_out_q[$];
    int        errors = 0;

    function automatic void add_letter(int idx);
        if (fill < ALPHABET_SIZE)
        begin
            key_table[fill] = IDX_W'(idx);
            fill++;
        end
        taken[idx] = 1'b1;
    endfunction

    // advances the predicted state by one request and returns its response
    function automatic kwsc_out_t encipher(kwsc_in_t item);
        kwsc_out_t res;
        int        idx;
        logic      is_letter;
        res.data_out = item.data_in;
        res.status   = ST_OK;
        idx          = int'(item.data_in) - int'(FIRST_LETTER);
        is_letter    = (idx >= 0) && (idx < ALPHABET_SIZE);
        case (item.opcode)
            OP_CLEAR:
            begin
                taken  = '0;
                fill   = 0;
                sealed = 1'b0;
            end
            OP_KEY:
            begin
                if (sealed || !is_letter || taken[idx])
                    res.status = ST_IGNORED;
                else
                    add_letter(idx);
            end
            OP_FINISH:
            begin
                if (sealed)
                begin
                    res.status = ST_IGNORED;
                end
                else
                begin
                    for (int k = 0; k < ALPHABET_SIZE; k++)
                        if (!taken[k])
                            add_letter(k);
                    sealed = 1'b1;
                end
            end
            default:
            begin
                if (!sealed)
                    res.status = ST_NOT_READY;
                else if (is_letter)
                    res.data_out = FIRST_LETTER + 8'(key_table[idx]);
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kwsc_out_t want;
        if (!rst_n)
        begin
            taken  = '0;
            fill   = 0;
            sealed = 1'b0;
            cipher_out_q.delete();
            outstanding <= 0;
            fail_count  <= errors;
        end
        else
        begin
            // compare before pushing so a response that comes with its own request is caught
            if (rsp_valid && rsp_ready)
            begin
                if (cipher_out_q.size() == 0)
                begin
                    $error("response with nothing expected: data_out %0h status %0d",
                           rsp.data_out, rsp.status);
                    errors++;
                end
                else
                begin
                    want = cipher_out_q.pop_front();
                    if (rsp.data_out !== want.data_out)
                    begin
                        $error("data_out mismatch: expected %0h, actual %0h",
                               want.data_out, rsp.data_out);
                        errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp.status);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
                cipher_out_q.push_back(encipher(req));
            outstanding <= cipher_out_q.size();
            fail_count  <= errors;
        end
    end

endmodule

[sim/tb_keyword_substitution_cipher.sv]
// tb_keyword_substitution_cipher: stimulus, clock, reset and verdict for the
// keyword substitution cipher; depends on kwsc_pkg, keyword_substitution_cipher
// and kwsc_cipher_checker

module tb_keyword_substitution_cipher;
    import kwsc_pkg::*;

    localparam int CLEARING_CYCLES = 40;    // finish walks the whole alphabet
    localparam int STALL_LIMIT     = 1000;  // cycles with no transaction at all
    localparam int RANDOM_ITEMS    = 800;
    localparam int CALM_TAIL       = 200;   // longer than one key schedule, so the
                                            // last schedules go without idling

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    kwsc_in_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    kwsc_out_t rsp;

    int   fail_count;
    int   outstanding;
    logic idle_on;      // enables random gaps on both sides
    int   hold_cnt = 0;
    int   sent = 0;
    int   op_count [4];
    int   schedules = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    keyword_substitution_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    kwsc_cipher_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receive side: ready drops for random bursts while idling is on
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            rsp_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            hold_cnt  <= $urandom_range(0, 14);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // one request transaction; valid stays high across back-to-back requests so
    // it never gets a low and a high in the same time step
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req.opcode   <= op;
        req.data_in  <= b;
        do @(posedge clk); while (!req_ready);
        op_count[op]++;
        sent++;
    endtask

    // sender holds off until every response has come back; outstanding is
    // registered, so it is read only after its register has updated
    task automatic drain_responses();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // watchdog: ends the run if the channels go quiet for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int   perm [ALPHABET_SIZE];
        int   klen;
        int   nenc;
        int   j;
        int   tmp;
        logic calm;
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        idle_on   = 1'b0;
        op_count  = '{default: 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, back to back
        send_item(OP_ENCRYPT, "A");     // encrypt before any table exists
        send_item(OP_KEY, 8'h00);       // non-letter key bytes at both ends
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, "@");         // just below and just above the letters
        send_item(OP_KEY, "[");
        send_item(OP_KEY, "a");         // lowercase is not a letter here
        send_item(OP_KEY, "Z");
        send_item(OP_KEY, "E");
        send_item(OP_KEY, "A");
        send_item(OP_KEY, "Z");         // repeated letter
        send_item(OP_ENCRYPT, "B");     // table still open
        send_item(OP_FINISH, 8'h00);
        send_item(OP_KEY, "Q");         // key letter on a sealed table
        send_item(OP_FINISH, 8'hFF);    // finish on a sealed table
        send_item(OP_ENCRYPT, "A");
        send_item(OP_ENCRYPT, "Z");
        send_item(OP_ENCRYPT, "M");
        send_item(OP_ENCRYPT, 8'h00);   // non-letters pass through
        send_item(OP_ENCRYPT, 8'hFF);
        send_item(OP_ENCRYPT, "z");
        send_item(OP_CLEAR, 8'h5A);
        send_item(OP_ENCRYPT, "B");     // cleared table is not ready
        send_item(OP_FINISH, 8'h41);    // empty keyword gives the plain alphabet
        send_item(OP_ENCRYPT, "Q");
        drain_responses();

        // random part: mostly whole key schedules followed by encrypt streams
        while (sent < 24 + RANDOM_ITEMS)
        begin
            calm    = ($urandom_range(0, 3) == 0);
            idle_on = !calm && (sent < 24 + RANDOM_ITEMS - CALM_TAIL);
            schedules++;
            if ($urandom_range(0, 7) != 0)
                send_item(OP_CLEAR, 8'($urandom));

            if ($urandom_range(0, 11) == 0)
            begin
                // full alphabet as keyword, so finish has nothing left to add
                for (int i = 0; i < ALPHABET_SIZE; i++)
                    perm[i] = i;
                for (int i = ALPHABET_SIZE - 1; i > 0; i--)
                begin
                    j       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (int i = 0; i < ALPHABET_SIZE; i++)
                    send_item(OP_KEY, FIRST_LETTER + 8'(perm[i]));
            end
            else
            begin
                klen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 14);
                for (int i = 0; i < klen; i++)
                    if ($urandom_range(0, 7) == 0)
                        send_item(OP_KEY, 8'($urandom));
                    else
                        send_item(OP_KEY, FIRST_LETTER +
                                  8'($urandom_range(0, ALPHABET_SIZE - 1)));
            end

            // now and then the finish is left out so encrypts see an open table
            if ($urandom_range(0, 7) != 0)
                send_item(OP_FINISH, 8'($urandom));

            nenc = $urandom_range(4, 40);
            for (int i = 0; i < nenc; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item($urandom_range(0, 1) ? OP_KEY : OP_FINISH, 8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_ENCRYPT, 8'($urandom));
                else
                    send_item(OP_ENCRYPT, FIRST_LETTER +
                              8'($urandom_range(0, ALPHABET_SIZE - 1)));
            end

            if ($urandom_range(0, 9) == 0)
                drain_responses();
        end

        // wind down: everything back, then let a late finish settle
        idle_on = 1'b0;
        drain_responses();
        repeat (CLEARING_CYCLES) @(posedge clk);

        $display("covered %0d requests over %0d key schedules: %0d clear, %0d key, %0d finish",
                 sent, schedules, op_count[OP_CLEAR], op_count[OP_KEY], op_count[OP_FINISH]);
        $display("and %0d encrypt bytes, with random gaps and response stalls",
                 op_count[OP_ENCRYPT]);
        if (fail_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
